// ===== rtl/core/owc_pkg.sv =====
// ----------------------------------------------------------------------------
// owc_pkg
// shared types and constants of the additive wavetable oscillator
// ----------------------------------------------------------------------------
package owc_pkg;

	localparam int WAVE_DEPTH    = 4096;
	localparam int MAX_HARMONICS = 64;

	localparam int POS_W  = $clog2(WAVE_DEPTH);
	localparam int HIDX_W = $clog2(MAX_HARMONICS);
	localparam int HCNT_W = 7;
	localparam int HNUM_W = HIDX_W + 1;
	localparam int AMP_W  = 16;
	localparam int WAVE_W = 16;
	localparam int PROD_W = WAVE_W + AMP_W + 1;
	localparam int ACC_W  = PROD_W + HIDX_W + 2;
	localparam int OUT_W  = 24;
	localparam int FRAC_SHIFT = 14;

	localparam logic [POS_W-1:0] QUARTER_OFFSET = POS_W'(WAVE_DEPTH / 4);

	// commands
	localparam logic [1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [1:0] CMD_LOAD_AMP  = 2'd1;
	localparam logic [1:0] CMD_LOAD_WAVE = 2'd2;

	// waveform kinds
	localparam logic [1:0] KIND_SINE     = 2'd0;
	localparam logic [1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [1:0] KIND_SAWTOOTH = 2'd2;
	localparam logic [1:0] KIND_SQUARE   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_WAVEFORM_KIND  = 2'd0;
	localparam logic [1:0] REG_HARMONIC_COUNT = 2'd1;

	// per-sample context held for the whole sweep
	typedef struct packed {
		logic             advance;
		logic [1:0]       kind;
		logic [POS_W-1:0] master;
		logic [POS_W-1:0] stp;
	} owc_ctx_t;

	// one harmonic handed from the phase unit to the mac
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
		logic [AMP_W-1:0] amp;
	} owc_term_t;

	// amplitude store write port
	typedef struct packed {
		logic              en;
		logic [HIDX_W-1:0] addr;
		logic [AMP_W-1:0]  data;
	} owc_amp_wr_t;

	// wave store write port
	typedef struct packed {
		logic              en;
		logic [POS_W-1:0]  addr;
		logic [WAVE_W-1:0] data;
	} owc_wave_wr_t;

	// harmonic number of slot i for a waveform kind
	function automatic logic [HNUM_W-1:0] harm_number(input logic [1:0] kind,
			input logic [HIDX_W-1:0] i);
		logic [HNUM_W-1:0] h;
		unique case (kind)
			KIND_SINE:     h = HNUM_W'(1);
			KIND_SAWTOOTH: h = {1'b0, i} + HNUM_W'(1);
			default:       h = {i, 1'b1};
		endcase
		return h;
	endfunction

endpackage

// ===== rtl/core/owc_phase_unit.sv =====
// ----------------------------------------------------------------------------
// owc_phase_unit
// position and amplitude stores with the read-modify-write of each position
// ----------------------------------------------------------------------------
module owc_phase_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       issue,
	input  logic [owc_pkg::HIDX_W-1:0] issue_idx,
	input  owc_pkg::owc_ctx_t          ctx,
	input  owc_pkg::owc_amp_wr_t       amp_wr,
	output owc_pkg::owc_term_t         term,
	output logic                       busy
);
	import owc_pkg::*;

	logic [POS_W-1:0] pos_mem [MAX_HARMONICS];
	logic [AMP_W-1:0] amp_mem [MAX_HARMONICS];

	logic              valid_s1;
	logic [HIDX_W-1:0] idx_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [AMP_W-1:0]  amp_s1;

	logic [HNUM_W-1:0]       h;
	logic [POS_W-1:0]        base;
	logic [POS_W-1:0]        mul_a;
	logic [POS_W+HNUM_W-1:0] prod;
	logic [POS_W-1:0]        new_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		pos_s1 <= pos_mem[issue_idx];
		if (valid_s1) begin
			pos_mem[idx_s1] <= new_pos;
		end
	end

	always_ff @(posedge clk) begin
		amp_s1 <= amp_mem[issue_idx];
		if (amp_wr.en) begin
			amp_mem[amp_wr.addr] <= amp_wr.data;
		end
	end

	// advance: old position plus step times h; resync: master times h plus offset
	always_comb begin
		h       = harm_number(ctx.kind, idx_s1);
		base    = ctx.advance ? pos_s1 : ((ctx.kind == KIND_TRIANGLE) ? QUARTER_OFFSET : '0);
		mul_a   = ctx.advance ? ctx.stp : ctx.master;
		prod    = mul_a * h;
		new_pos = base + prod[POS_W-1:0];
	end

	assign term.valid = valid_s1;
	assign term.pos   = new_pos;
	assign term.amp   = amp_s1;
	assign busy       = valid_s1;

endmodule

// ===== rtl/core/owc_wave_mac.sv =====
// ----------------------------------------------------------------------------
// owc_wave_mac
// wave store lookup, amplitude multiply and accumulate
// ----------------------------------------------------------------------------
module owc_wave_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  owc_pkg::owc_term_t               term,
	input  owc_pkg::owc_wave_wr_t            wave_wr,
	output logic signed [owc_pkg::ACC_W-1:0] acc,
	output logic                             busy
);
	import owc_pkg::*;

	logic [WAVE_W-1:0] wave_mem [WAVE_DEPTH];

	logic                     valid_s2;
	logic [WAVE_W-1:0]        wave_s2;
	logic [AMP_W-1:0]         amp_s2;
	logic                     valid_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		wave_s2 <= wave_mem[term.pos];
		if (wave_wr.en) begin
			wave_mem[wave_wr.addr] <= wave_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		amp_s2  <= term.amp;
		prod_s3 <= PROD_W'($signed(wave_s2) * $signed({1'b0, amp_s2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s2 <= term.valid;
			valid_s3 <= valid_s2;
			if (clear) begin
				acc_q <= '0;
			end else if (valid_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = valid_s2 | valid_s3;

endmodule

// ===== rtl/core/additive_wavetable_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// additive_wavetable_oscillator_core
// band-limited additive oscillator summing wavetable harmonics
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid/in_ready) carries one command per beat: a sample
//    request, an amplitude load or a wavetable load
//  - loads are taken while the sequencer is idle and give no output beat
//  - a sample request sweeps the active harmonics one per cycle through the
//    position store (read, update, write back), the wave store and the mac
//  - after the last harmonic is issued the lookup, multiply and accumulate
//    stages empty and the rounded sum enters the output register; the
//    sequencer returns to idle as out_valid rises, so the next command can
//    be taken while the result waits
//  - config channel (cfg_valid/cfg_ready) writes waveform_kind and
//    harmonic_count; it is always ready and a write to either register forces
//    the next sample to recompute all positions
//  - output channel (out_valid/out_ready) is a single output register; a new
//    command is taken while a result waits, but a finished sample holds until
//    the register is free
//  - reset clears the sequencer, the sync flag and the registers; the stores
//    are not cleared, as the first sample always recomputes positions
// ----------------------------------------------------------------------------
module additive_wavetable_oscillator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// config
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [owc_pkg::HCNT_W-1:0]        cfg_data,
	// input beats
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [11:0]                       master_pos,
	input  logic [11:0]                       step,
	input  logic [11:0]                       load_index,
	input  logic [15:0]                       amplitude,
	input  logic signed [15:0]                table_value,
	// output beats
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [owc_pkg::OUT_W-1:0]  sample_out,
	output logic                              resynced
);
	import owc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam int SUM_W = ACC_W - FRAC_SHIFT;

	// saturation bounds of the output word
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (OUT_W - 1)));

	logic [1:0] state_q;

	// registers
	logic [1:0]        kind_q;
	logic [HCNT_W-1:0] count_q;
	logic              in_sync_q;
	logic [POS_W-1:0]  last_master_q;

	// sample context
	owc_ctx_t          ctx_q;
	logic [HCNT_W-1:0] n_q;
	logic [HCNT_W-1:0] idx_q;

	// output register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] sample_q;
	logic                    resynced_q;

	logic              in_beat;
	logic              cfg_beat;
	logic              sample_beat;
	logic [POS_W-1:0]  master_m;
	logic [POS_W-1:0]  stp_m;
	logic              advance;
	logic [HCNT_W-1:0] active_n;
	logic              issue;
	logic              last_issue;
	logic              phase_busy;
	logic              mac_busy;
	logic              finish;

	owc_term_t    term;
	owc_amp_wr_t  amp_wr;
	owc_wave_wr_t wave_wr;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] rnd;
	logic signed [SUM_W-1:0] shifted;
	logic signed [OUT_W-1:0] sat;

	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid & cfg_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid & in_ready;
	assign sample_beat = in_beat & (cmd == CMD_SAMPLE);

	// positions wrap at the table size
	assign master_m = master_pos[POS_W-1:0];
	assign stp_m    = step[POS_W-1:0];
	assign advance  = in_sync_q & (master_m == POS_W'(last_master_q + stp_m));

	// sine uses one harmonic, zero counts as one, large counts saturate
	always_comb begin
		if (kind_q == KIND_SINE || count_q == '0) begin
			active_n = HCNT_W'(1);
		end else if (count_q > HCNT_W'(MAX_HARMONICS)) begin
			active_n = HCNT_W'(MAX_HARMONICS);
		end else begin
			active_n = count_q;
		end
	end

	// load ports
	assign amp_wr.en    = in_beat & (cmd == CMD_LOAD_AMP) & (load_index < 12'(MAX_HARMONICS));
	assign amp_wr.addr  = load_index[HIDX_W-1:0];
	assign amp_wr.data  = amplitude;
	assign wave_wr.en   = in_beat & (cmd == CMD_LOAD_WAVE);
	assign wave_wr.addr = load_index[POS_W-1:0];
	assign wave_wr.data = table_value;

	assign issue      = (state_q == ST_RUN);
	assign last_issue = (idx_q == n_q - HCNT_W'(1));

	owc_phase_unit u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.issue_idx (idx_q[HIDX_W-1:0]),
		.ctx       (ctx_q),
		.amp_wr    (amp_wr),
		.term      (term),
		.busy      (phase_busy)
	);

	owc_wave_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (sample_beat),
		.term    (term),
		.wave_wr (wave_wr),
		.acc     (acc),
		.busy    (mac_busy)
	);

	// round off the q.14 fraction and saturate
	always_comb begin
		rnd     = acc + ACC_W'(1 << (FRAC_SHIFT - 1));
		shifted = SUM_W'(rnd >>> FRAC_SHIFT);
		if (shifted > SAT_HI) begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (shifted < SAT_LO) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = OUT_W'(shifted);
		end
	end

	// finished once the pipeline is empty and the output register is free
	assign finish = (state_q == ST_DRAIN) & ~phase_busy & ~mac_busy &
		(~out_valid_q | out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (sample_beat) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					idx_q <= idx_q + HCNT_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample context
	always_ff @(posedge clk) begin
		if (sample_beat) begin
			ctx_q.advance <= advance;
			ctx_q.kind    <= kind_q;
			ctx_q.master  <= master_m;
			ctx_q.stp     <= stp_m;
			n_q           <= active_n;
		end
	end

	// registers and sync tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_SINE;
			count_q       <= HCNT_W'(1);
			in_sync_q     <= 1'b0;
			last_master_q <= '0;
		end else begin
			if (cfg_beat && cfg_index == REG_WAVEFORM_KIND) begin
				kind_q    <= cfg_data[1:0];
				in_sync_q <= 1'b0;
			end else if (cfg_beat && cfg_index == REG_HARMONIC_COUNT) begin
				count_q   <= cfg_data;
				in_sync_q <= 1'b0;
			end else if (sample_beat) begin
				in_sync_q <= 1'b1;
			end
			if (sample_beat) begin
				last_master_q <= master_m;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sample_q   <= sat;
			resynced_q <= ~ctx_q.advance;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign resynced   = resynced_q;

endmodule

// ===== dv/tb_additive_wavetable_oscillator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_additive_wavetable_oscillator_core
// self-checking bench for the additive wavetable oscillator: preloads the
// amplitude store and the wavetable words on a coarse grid (sample positions
// stay on that grid), runs a short directed sequence, then random command
// streams under several waveform settings and idling patterns. Each sample
// beat is predicted by a scoreboard class holding its own copy of the stores.
// ----------------------------------------------------------------------------
module tb_additive_wavetable_oscillator_core;
	import owc_pkg::*;

	// cmd 3 has no meaning in the block and must be dropped
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam int          PHASES      = 10;
	localparam int          PHASE_ITEMS = 135;
	// settle time, longer than the longest sample of 64 harmonics
	localparam int          SETTLE      = 80;
	localparam int unsigned LIMIT       = 4000000;
	// masters and steps on this grid keep every position on preloaded words
	localparam int          GRID        = 16;
	localparam logic [11:0] GRID_MASK   = 12'(WAVE_DEPTH - GRID);

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one input beat
	typedef struct {
		logic [1:0]         cmd;
		logic [11:0]        master;
		logic [11:0]        stp;
		logic [11:0]        idx;
		logic [15:0]        amp;
		logic signed [15:0] wave;
	} osc_beat_t;

	// one output beat
	typedef struct {
		logic signed [OUT_W-1:0] level;
		logic                    resynced;
	} osc_sample_t;

	// ------------------------------------------------------------------------
	// scoreboard: predicts each sample and checks the output beats in order
	// ------------------------------------------------------------------------
	class sample_scoreboard;
		logic [1:0]         kind;
		logic [HCNT_W-1:0]  count;
		logic [POS_W-1:0]   positions [MAX_HARMONICS];
		logic [15:0]        amp_store [MAX_HARMONICS];
		logic signed [15:0] wave_store [WAVE_DEPTH];
		logic [POS_W-1:0]   last_master;
		bit                 in_sync;
		osc_sample_t        pending [$];
		int                 errors;

		function new();
			kind        = KIND_SINE;
			count       = HCNT_W'(1);
			last_master = '0;
			in_sync     = 1'b0;
			errors      = 0;
			foreach (positions[i]) positions[i] = '0;
			foreach (amp_store[i]) amp_store[i] = '0;
			foreach (wave_store[i]) wave_store[i] = '0;
		endfunction

		// any register write forces the next sample to recompute
		function void write_register(logic [1:0] index, logic [HCNT_W-1:0] value);
			if (index == REG_WAVEFORM_KIND)
				kind = value[1:0];
			else if (index == REG_HARMONIC_COUNT)
				count = value;
			in_sync = 1'b0;
		endfunction

		// note an accepted input beat, working out its sample if it makes one
		function void note_beat(osc_beat_t b);
			int unsigned n, h, offs, i;
			longint      acc, r;
			bit          adv;
			logic [POS_W-1:0] pos;
			osc_sample_t e;
			case (b.cmd)
				CMD_LOAD_AMP: begin
					if (b.idx < MAX_HARMONICS)
						amp_store[b.idx] = b.amp;
				end
				CMD_LOAD_WAVE: begin
					wave_store[b.idx] = b.wave;
				end
				CMD_SAMPLE: begin
					offs = (kind == KIND_TRIANGLE) ? WAVE_DEPTH / 4 : 0;
					adv  = in_sync && (b.master == POS_W'(last_master + b.stp));
					if (kind == KIND_SINE || count == 0)
						n = 1;
					else if (count > MAX_HARMONICS)
						n = MAX_HARMONICS;
					else
						n = int'(count);
					acc = 0;
					for (i = 0; i < n; i++) begin
						if (kind == KIND_SINE)
							h = 1;
						else if (kind == KIND_SAWTOOTH)
							h = i + 1;
						else
							h = 2 * i + 1;
						if (adv)
							pos = POS_W'(positions[i] + b.stp * h);
						else
							pos = POS_W'(b.master * h + offs);
						positions[i] = pos;
						acc += longint'(wave_store[pos]) * longint'(amp_store[i]);
					end
					r = (acc + 8192) >>> FRAC_SHIFT;
					if (r > 8388607)
						r = 8388607;
					if (r < -8388608)
						r = -8388608;
					e.level    = OUT_W'(r);
					e.resynced = !adv;
					pending.push_back(e);
					last_master = b.master;
					in_sync     = 1'b1;
				end
				default: ;
			endcase
		endfunction

		// compare one output beat with the oldest prediction
		function void check_sample(logic signed [OUT_W-1:0] level, logic resynced);
			osc_sample_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t  unexpected sample: expected none, actual %0d resynced %0b",
					$time, level, resynced);
				return;
			end
			e = pending.pop_front();
			if (level !== e.level) begin
				errors++;
				$display("%0t  sample_out: expected %0d, actual %0d", $time, e.level, level);
			end
			if (resynced !== e.resynced) begin
				errors++;
				$display("%0t  resynced: expected %0b, actual %0b", $time, e.resynced,
					resynced);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                    clk             = 1'b0;
	logic                    arst_n          = 1'b0;
	logic                    cfg_valid       = 1'b0;
	logic                    cfg_ready;
	logic [1:0]              cfg_index       = '0;
	logic [HCNT_W-1:0]       cfg_data        = '0;
	logic                    in_valid        = 1'b0;
	logic                    in_ready;
	logic [1:0]              cmd             = '0;
	logic [11:0]             master_pos      = '0;
	logic [11:0]             step            = '0;
	logic [11:0]             load_index      = '0;
	logic [15:0]             amplitude       = '0;
	logic signed [15:0]      table_value     = '0;
	logic                    out_valid;
	logic                    out_ready       = 1'b0;
	logic signed [OUT_W-1:0] sample_out;
	logic                    resynced;

	sample_scoreboard sb = new();
	idle_mode_t       idle_mode = IDLE_NONE;
	int unsigned      cycle_count = 0;
	// running master of the well-formed sample stream
	logic [11:0]      seq_master = '0;
	logic [11:0]      seq_step   = 12'(GRID);

	always #2 clk = ~clk;

	additive_wavetable_oscillator_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.master_pos      (master_pos),
		.step            (step),
		.load_index      (load_index),
		.amplitude       (amplitude),
		.table_value     (table_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_out      (sample_out),
		.resynced        (resynced)
	);

	// percentage of cycles that a side spends idle in the current mode
	function automatic int unsigned idle_pct(idle_mode_t m, bit receiver);
		if (m == IDLE_BOTH)
			return 11;
		if ((m == IDLE_SENDER && !receiver) || (m == IDLE_RECEIVER && receiver))
			return 73;
		return 0;
	endfunction

	function automatic osc_beat_t make_beat(logic [1:0] c, logic [11:0] m, logic [11:0] s,
			logic [11:0] idx, logic [15:0] amp, logic signed [15:0] wave);
		osc_beat_t b;
		b.cmd    = c;
		b.master = m;
		b.stp    = s;
		b.idx    = idx;
		b.amp    = amp;
		b.wave   = wave;
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// drivers, always entered and left on a rising edge
	// ------------------------------------------------------------------------

	// present one beat, with a random gap first, and hold it until taken
	task automatic send_beat(input osc_beat_t b);
		if ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct(idle_mode, 1'b0));
		end
		in_valid        <= 1'b1;
		cmd             <= b.cmd;
		master_pos      <= b.master;
		step            <= b.stp;
		load_index      <= b.idx;
		amplitude       <= b.amp;
		table_value     <= b.wave;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_beat(b);
	endtask

	// stop sending until every predicted sample is out, then let loads finish
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly continuous sample streams, with loads, breaks and junk mixed in
	task automatic random_items(input int total);
		osc_beat_t b;
		int        done, pick;
		done = 0;
		while (done < total) begin
			b = make_beat(2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
				16'($urandom), 16'($urandom));
			b.master = b.master & GRID_MASK;
			b.stp    = b.stp & GRID_MASK;
			pick = $urandom_range(99);
			if (pick < 55) begin
				// continue the stream, now and then with a new or extreme step
				b.cmd = CMD_SAMPLE;
				if ($urandom_range(4) == 0)
					case ($urandom_range(3))
						0:       seq_step = 12'd0;
						1:       seq_step = GRID_MASK;
						default: seq_step = 12'($urandom) & GRID_MASK;
					endcase
				b.stp    = seq_step;
				b.master = seq_master + seq_step;
			end else if (pick < 65) begin
				// broken stream: random master and step
				b.cmd = CMD_SAMPLE;
			end else if (pick < 80) begin
				b.cmd = CMD_LOAD_AMP;
				if ($urandom_range(9) != 0)
					b.idx = 12'($urandom_range(MAX_HARMONICS - 1));
				if ($urandom_range(9) < 7)
					b.amp = 16'($urandom_range(32768));
			end else if (pick < 95) begin
				// mostly rewrite words that samples read
				b.cmd = CMD_LOAD_WAVE;
				if ($urandom_range(3) != 0)
					b.idx = b.idx & GRID_MASK;
			end else begin
				b.cmd = CMD_UNKNOWN;
			end
			// rare hold-off until the block has emptied
			if ($urandom_range(199) == 0)
				drain_results();
			send_beat(b);
			if (b.cmd == CMD_SAMPLE)
				seq_master = b.master;
			if (b.cmd == CMD_SAMPLE || b.cmd == CMD_LOAD_WAVE ||
					(b.cmd == CMD_LOAD_AMP && b.idx < MAX_HARMONICS))
				done++;
		end
	endtask

	// ------------------------------------------------------------------------
	// receiver: checks each output beat, stalls by mode
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			sb.check_sample(sample_out, resynced);
		out_ready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb_additive_wavetable_oscillator_core NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int                p, a;
		logic [1:0]        kind_sel;
		logic [HCNT_W-1:0] count_sel;
		idle_mode_t        mode_sel;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// fill every amplitude and every grid word so no sample reads an unwritten one
		for (a = 0; a < MAX_HARMONICS; a++)
			send_beat(make_beat(CMD_LOAD_AMP, 12'($urandom), 12'($urandom), 12'(a),
				16'($urandom), 16'($urandom)));
		for (a = 0; a < WAVE_DEPTH; a += GRID)
			send_beat(make_beat(CMD_LOAD_WAVE, 12'($urandom), 12'($urandom), 12'(a),
				16'($urandom), 16'($urandom)));

		// one sample under the reset settings
		send_beat(make_beat(CMD_SAMPLE, 12'($urandom) & GRID_MASK,
			12'($urandom) & GRID_MASK, '0, '0, '0));

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: begin
					kind_sel = KIND_SAWTOOTH; count_sel = HCNT_W'(64);  mode_sel = IDLE_NONE;
				end
				1: begin
					kind_sel = KIND_SINE;     count_sel = HCNT_W'(1);   mode_sel = IDLE_NONE;
				end
				2: begin
					kind_sel = KIND_TRIANGLE; count_sel = HCNT_W'(5);   mode_sel = IDLE_SENDER;
				end
				3: begin
					kind_sel = KIND_SAWTOOTH; count_sel = HCNT_W'(3);   mode_sel = IDLE_RECEIVER;
				end
				4: begin
					kind_sel = KIND_SQUARE;   count_sel = HCNT_W'(0);   mode_sel = IDLE_BOTH;
				end
				5: begin
					kind_sel = KIND_TRIANGLE; count_sel = HCNT_W'(127); mode_sel = IDLE_NONE;
				end
				6: begin
					kind_sel = KIND_SAWTOOTH; count_sel = HCNT_W'(64);  mode_sel = IDLE_SENDER;
				end
				7: begin
					kind_sel = KIND_SQUARE;   count_sel = HCNT_W'(7);   mode_sel = IDLE_RECEIVER;
				end
				8: begin
					kind_sel = KIND_SINE;     count_sel = HCNT_W'(40);  mode_sel = IDLE_BOTH;
				end
				default: begin
					kind_sel = KIND_SAWTOOTH; count_sel = HCNT_W'(2);   mode_sel = IDLE_NONE;
				end
			endcase

			// both registers back to back while the block is idle
			cfg_valid <= 1'b1;
			cfg_index <= REG_WAVEFORM_KIND;
			cfg_data  <= HCNT_W'(kind_sel);
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.write_register(REG_WAVEFORM_KIND, HCNT_W'(kind_sel));
			cfg_index <= REG_HARMONIC_COUNT;
			cfg_data  <= count_sel;
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.write_register(REG_HARMONIC_COUNT, count_sel);
			cfg_valid <= 1'b0;
			idle_mode = mode_sel;

			if (p == 0) begin
				// first sample after a write recomputes, then in-step samples advance
				send_beat(make_beat(CMD_SAMPLE, 12'd0, 12'd0, '0, '0, '0));
				send_beat(make_beat(CMD_SAMPLE, 12'd0, 12'd0, '0, '0, '0));
				send_beat(make_beat(CMD_SAMPLE, 12'hff0, 12'hff0, '0, '0, '0));
				// master wraps round the table
				send_beat(make_beat(CMD_SAMPLE, 12'hfe0, 12'hff0, '0, '0, '0));
				// out of step, so a resync
				send_beat(make_beat(CMD_SAMPLE, 12'd1232, 12'd112, '0, '0, '0));
				// table and amplitude extremes
				send_beat(make_beat(CMD_LOAD_WAVE, '0, '0, 12'hff0, '0, 16'sh7fff));
				send_beat(make_beat(CMD_LOAD_WAVE, '0, '0, 12'd0, '0, 16'sh8000));
				send_beat(make_beat(CMD_LOAD_AMP, '0, '0, 12'd0, 16'hffff, '0));
				send_beat(make_beat(CMD_LOAD_AMP, '0, '0, 12'd63, 16'd0, '0));
				send_beat(make_beat(CMD_LOAD_AMP, '0, '0, 12'd32, 16'd32768, '0));
				// amplitude loads beyond the last harmonic are dropped
				send_beat(make_beat(CMD_LOAD_AMP, '0, '0, 12'd64, 16'h1234, '0));
				send_beat(make_beat(CMD_LOAD_AMP, '0, '0, 12'hfff, 16'hffff, '0));
				// unknown command, every field at its top
				send_beat(make_beat(CMD_UNKNOWN, 12'hfff, 12'hfff, 12'hfff, 16'hffff, 16'shffff));
				// every harmonic lands on the most negative word
				send_beat(make_beat(CMD_SAMPLE, 12'd0, 12'd80, '0, '0, '0));
				send_beat(make_beat(CMD_LOAD_WAVE, '0, '0, 12'd0, '0, 16'sh7fff));
				send_beat(make_beat(CMD_SAMPLE, 12'd80, 12'd80, '0, '0, '0));
				send_beat(make_beat(CMD_SAMPLE, 12'hff0, 12'd0, '0, '0, '0));
				// zero step keeps the positions where they are
				send_beat(make_beat(CMD_SAMPLE, 12'hff0, 12'd0, '0, '0, '0));
				seq_master = 12'hff0;
			end else begin
				random_items(PHASE_ITEMS);
			end
		end

		drain_results();
		if (sb.errors == 0)
			$display("tb_additive_wavetable_oscillator_core OK");
		else
			$display("tb_additive_wavetable_oscillator_core NOT OK");
		$finish;
	end

endmodule
